[sv/ge3_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and helpers of the 3x3 gray erosion unit
package ge3_pkg;

  localparam int MaxWidth   = 2048;
  localparam int ColW       = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RowW       = 16;
  localparam int PixW       = 8;
  localparam int CfgW       = 16;
  localparam int WidthRegW  = 12;
  localparam int LineW      = 2 * PixW;
  localparam int DefWidth   = 640;
  localparam int DefHeight  = 480;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [ColW-1:0] ResetWLast =
    ColW'(((DefWidth > MaxWidth) ? MaxWidth : DefWidth) - 1);
  localparam logic [RowW-1:0] ResetHLast = RowW'(DefHeight - 1);

  typedef enum logic [0:0] {
    CfgWidth  = 1'b0,
    CfgHeight = 1'b1
  } cfg_idx_e;

  // result slot: {current row, current column}
  typedef enum logic [1:0] {
    SlotPrevPrev = 2'd0,
    SlotPrevCur  = 2'd1,
    SlotCurPrev  = 2'd2,
    SlotCurCur   = 2'd3
  } slot_e;

  typedef logic [PixW-1:0] pix_t;

  // one input's worth of results
  typedef struct packed {
    pix_t [3:0]      mins;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [3:0]      mask;
  } run_t;

  function automatic pix_t min8(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

[sv/gray_erode_3x3_unit.sv]
`timescale 1ns / 1ps
// top level of the streaming 3x3 gray erosion unit
//
// Takes one 8-bit pixel per clock in raster order and returns the minimum of
// each pixel's 3x3 neighbourhood, edges replicated. An input item is taken
// every cycle while the four-entry run queue, counted together with the item
// still in the window stage, has room. The line store read (one read and one
// write port per cycle) is issued at acceptance; the accepted item is then
// registered in the window stage, from which its results enter the queue, and
// the back end presents each result from its output register. An item
// releases zero to four results: one in the body of the frame, two at the
// last column or on the bottom row, four at the bottom-right pixel. Results
// leave one per cycle while the output is not stalled, so on the bottom row
// the back end sets the rate. The line store holds two rows of up to
// 2048 pixels; it is not cleared and needs no start-up pass. Any
// configuration write restarts the frame at the top-left pixel.
module gray_erode_3x3_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [ge3_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ge3_pkg::PixW-1:0] pixel_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ge3_pkg::PixW-1:0] pixel_out_o,
  output logic [ge3_pkg::ColW-1:0] out_column_o,
  output logic [ge3_pkg::RowW-1:0] out_row_o,
  output logic                     last_of_run_o,
  output logic                     end_of_frame_o
);

  logic                      push, pop;
  ge3_pkg::run_t             push_data, head;
  logic [ge3_pkg::QCntW-1:0] q_count;

  ge3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_in_i (pixel_in_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_data_o(push_data)
  );

  ge3_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .count_o    (q_count)
  );

  ge3_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (q_count != '0),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_out_o   (pixel_out_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o),
    .end_of_frame_o(end_of_frame_o)
  );

endmodule

[sv/ge3_ram.sv]
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read-first output
module ge3_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ge3_front.sv]
`timescale 1ns / 1ps
// front end: configuration, position tracking, line store and 3x3 window
module ge3_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [ge3_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ge3_pkg::PixW-1:0]  pixel_in_i,
  input  logic [ge3_pkg::QCntW-1:0] q_count_i,
  output logic                      push_o,
  output ge3_pkg::run_t             push_data_o
);

  logic [ge3_pkg::ColW-1:0] w_last_q, w_last_cfg;
  logic [ge3_pkg::RowW-1:0] h_last_q, h_last_cfg;
  logic [ge3_pkg::WidthRegW-1:0] wcfg;
  logic [ge3_pkg::ColW-1:0] x_q, x_d;
  logic [ge3_pkg::RowW-1:0] y_q, y_d;
  logic [ge3_pkg::QCntW:0] credit;
  logic accept;

  logic                     a_valid_q;
  ge3_pkg::pix_t            a_pix_q;
  logic [ge3_pkg::ColW-1:0] a_x_q;
  logic [ge3_pkg::RowW-1:0] a_y_q;
  logic                     a_y0_q, a_y1_q;
  logic [3:0]               a_mask_q, mask_d;

  logic [ge3_pkg::LineW-1:0] rd_word, wr_word, ld_word, fwd_word_q;
  logic                      fwd_q;
  ge3_pkg::pix_t             r1, r2;
  ge3_pkg::pix_t [2:0][2:0]  win_q, win_d;
  ge3_pkg::pix_t [2:0]       col_full, col_bot;
  ge3_pkg::pix_t [3:0]       mins;

  // configuration decode with clamping
  always_comb begin
    wcfg = cfg_data_i[ge3_pkg::WidthRegW-1:0];
    if (wcfg == '0) begin
      w_last_cfg = '0;
    end else if (32'(wcfg) > 32'(ge3_pkg::MaxWidth)) begin
      w_last_cfg = ge3_pkg::ColW'(ge3_pkg::MaxWidth - 1);
    end else begin
      w_last_cfg = ge3_pkg::ColW'(wcfg - 1'b1);
    end
    h_last_cfg = (cfg_data_i == '0) ? '0 : cfg_data_i - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= ge3_pkg::ResetWLast;
      h_last_q <= ge3_pkg::ResetHLast;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ge3_pkg::CfgWidth) begin
        w_last_q <= w_last_cfg;
      end else begin
        h_last_q <= h_last_cfg;
      end
    end
  end

  // input credit against the run queue
  assign credit     = {1'b0, q_count_i} + {{ge3_pkg::QCntW{1'b0}}, a_valid_q};
  assign in_stall_o = credit >= (ge3_pkg::QCntW + 1)'(ge3_pkg::QDepth);
  assign accept     = in_valid_i && !in_stall_o;

  // raster position
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (x_q == w_last_q) begin
      x_d = '0;
      y_d = (y_q == h_last_q) ? '0 : y_q + 1'b1;
    end else begin
      x_d = x_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cfg_we_i) begin
      x_q <= '0;
      y_q <= '0;
    end else if (accept) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // which results this item releases
  assign mask_d = {(y_q == h_last_q) && (x_q == w_last_q),
                   (y_q == h_last_q) && (x_q != '0),
                   (y_q != '0) && (x_q == w_last_q),
                   (y_q != '0) && (x_q != '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      a_valid_q <= accept;
      fwd_q     <= accept && a_valid_q && (x_q == a_x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q    <= pixel_in_i;
      a_x_q      <= x_q;
      a_y_q      <= y_q;
      a_y0_q     <= (y_q == '0);
      a_y1_q     <= (y_q == ge3_pkg::RowW'(1));
      a_mask_q   <= mask_d;
      fwd_word_q <= wr_word;
    end
  end

  // entry per column: {row above, two rows above}
  ge3_ram #(
    .Width(ge3_pkg::LineW),
    .Depth(ge3_pkg::MaxWidth)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (a_valid_q),
    .waddr_i(a_x_q),
    .wdata_i(wr_word),
    .re_i   (accept),
    .raddr_i(x_q),
    .rdata_o(rd_word)
  );

  always_comb begin
    ld_word = fwd_q ? fwd_word_q : rd_word;
    if (a_y0_q) begin
      r1 = a_pix_q;
      r2 = a_pix_q;
    end else begin
      r1 = ld_word[ge3_pkg::LineW-1:ge3_pkg::PixW];
      r2 = a_y1_q ? r1 : ld_word[ge3_pkg::PixW-1:0];
    end
    wr_word = {a_pix_q, r1};
  end

  // window shift, border replicated on the first column
  always_comb begin
    win_d[2] = {a_pix_q, r1, r2};
    if (a_x_q == '0) begin
      win_d[1] = {a_pix_q, r1, r2};
      win_d[0] = {a_pix_q, r1, r2};
    end else begin
      win_d[1] = win_q[2];
      win_d[0] = win_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_bot[c]  = ge3_pkg::min8(win_d[c][1], win_d[c][2]);
      col_full[c] = ge3_pkg::min8(col_bot[c], win_d[c][0]);
    end
    mins[ge3_pkg::SlotPrevCur]  = ge3_pkg::min8(col_full[1], col_full[2]);
    mins[ge3_pkg::SlotPrevPrev] = ge3_pkg::min8(mins[ge3_pkg::SlotPrevCur], col_full[0]);
    mins[ge3_pkg::SlotCurCur]   = ge3_pkg::min8(col_bot[1], col_bot[2]);
    mins[ge3_pkg::SlotCurPrev]  = ge3_pkg::min8(mins[ge3_pkg::SlotCurCur], col_bot[0]);
  end

  assign push_o           = a_valid_q && (a_mask_q != '0);
  assign push_data_o.mins = mins;
  assign push_data_o.col  = a_x_q;
  assign push_data_o.row  = a_y_q;
  assign push_data_o.mask = a_mask_q;

  a_fwd_only_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (w_last_q == '0))
    else $error("line store forwarding with width above one");

  a_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_q <= w_last_q)
    else $error("column position beyond frame width");

  a_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_q <= h_last_q)
    else $error("row position beyond frame height");

endmodule

[sv/ge3_fifo.sv]
`timescale 1ns / 1ps
// short queue of result runs between front and back ends
module ge3_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  ge3_pkg::run_t             push_data_i,
  input  logic                      pop_i,
  output ge3_pkg::run_t             head_o,
  output logic [ge3_pkg::QCntW-1:0] count_o
);

  ge3_pkg::run_t             mem_q [ge3_pkg::QDepth];
  logic [ge3_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ge3_pkg::QCntW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == ge3_pkg::QPtrW'(ge3_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == ge3_pkg::QPtrW'(ge3_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < ge3_pkg::QCntW'(ge3_pkg::QDepth)))
    else $error("run queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("run queue underflow");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (head_o.mask != '0))
    else $error("queued run carries no result");

endmodule

[sv/ge3_back.sv]
`timescale 1ns / 1ps
// back end: expands each run into result items, one per cycle while the output is not stalled
module ge3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ge3_pkg::run_t             head_i,
  input  logic                      head_valid_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ge3_pkg::PixW-1:0]  pixel_out_o,
  output logic [ge3_pkg::ColW-1:0]  out_column_o,
  output logic [ge3_pkg::RowW-1:0]  out_row_o,
  output logic                      last_of_run_o,
  output logic                      end_of_frame_o
);

  logic [3:0]     done_q, done_d, rem, pick;
  logic           load, last;
  ge3_pkg::slot_e slot;

  logic                     out_valid_q;
  ge3_pkg::pix_t            pix_q;
  logic [ge3_pkg::ColW-1:0] col_q;
  logic [ge3_pkg::RowW-1:0] row_q;
  logic                     last_q, eof_q;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);
  assign rem  = head_i.mask & ~done_q;
  assign pick = rem & (~rem + 4'd1);
  assign last = (rem & ~pick) == '0;
  assign pop_o = load && last;

  always_comb begin
    slot = ge3_pkg::SlotPrevPrev;
    case (pick)
      4'b0001: slot = ge3_pkg::SlotPrevPrev;
      4'b0010: slot = ge3_pkg::SlotPrevCur;
      4'b0100: slot = ge3_pkg::SlotCurPrev;
      4'b1000: slot = ge3_pkg::SlotCurCur;
      default: slot = ge3_pkg::SlotPrevPrev;
    endcase
  end

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = last ? '0 : (done_q | pick);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= head_i.mins[slot];
      col_q  <= slot[0] ? head_i.col : head_i.col - 1'b1;
      row_q  <= slot[1] ? head_i.row : head_i.row - 1'b1;
      last_q <= last;
      eof_q  <= (slot == ge3_pkg::SlotCurCur);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pix_q;
  assign out_column_o   = col_q;
  assign out_row_o      = row_q;
  assign last_of_run_o  = last_q;
  assign end_of_frame_o = eof_q;

  a_eof_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && eof_q) |-> last_q)
    else $error("frame end not on the last item of its run");

  a_load_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (rem != '0))
    else $error("result issued from an exhausted run");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (done_q == '0))
    else $error("slot tracking not cleared after a run");

endmodule
